[hw/rtl/plc_pkg.sv]
// Shared constants and types for the piecewise linear curve block.
// No dependencies; compiled first.
package plc_pkg;

  localparam int NODES  = 8;                 // breakpoint slots
  localparam int IDX_W  = $clog2(NODES);     // table index width
  localparam int CNT_W  = 4;                 // node_count register width
  localparam int DATA_W = 32;                // Q16.16 word

  // Quotient is capped at 2^33: anything larger saturates the result anyway.
  localparam int DIV_STEPS  = 33;
  localparam int DIV_BPS    = 3;             // quotient bits per divider stage
  localparam int DIV_STAGES = DIV_STEPS / DIV_BPS;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Sideband that rides along with the divider
  typedef struct packed {
    logic                     neg;   // result sign of the slope term
    logic                     zero;  // product was zero, quotient is 0
    logic                     sat;   // quotient at or above the cap
    logic signed [DATA_W-1:0] va;    // ordinate at the segment start
  } plc_side_t;

endpackage

[hw/rtl/plc_if.sv]
// Item channels of the piecewise linear curve block: request and result.
// Depends on plc_pkg for the word width.
interface plc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [2:0]                        node_index;
  logic signed [plc_pkg::DATA_W-1:0] node_param;
  logic signed [plc_pkg::DATA_W-1:0] node_value;
  logic signed [plc_pkg::DATA_W-1:0] query_param;

  modport source (output valid, command, node_index, node_param, node_value, query_param,
                  input ready);
  modport sink (input valid, command, node_index, node_param, node_value, query_param,
                output ready);
endinterface

interface plc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [plc_pkg::DATA_W-1:0] curve_value;

  modport source (output valid, curve_value, input ready);
  modport sink (input valid, curve_value, output ready);
endinterface

[hw/rtl/plc_div.sv]
// Pipelined restoring divider, DIV_BPS quotient bits per stage, with stall support.
// Depends on plc_pkg.
module plc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_rem,    // partial remainder, below divisor
  input  logic [32:0]               in_num,    // numerator bits still to shift in
  input  logic [31:0]               in_den,
  input  plc_pkg::plc_side_t        in_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [32:0]               out_quot,
  output plc_pkg::plc_side_t        out_side
);

  logic                      valid_r [plc_pkg::DIV_STAGES];
  logic [31:0]               rem_r   [plc_pkg::DIV_STAGES];
  logic [32:0]               nq_r    [plc_pkg::DIV_STAGES];
  logic [31:0]               den_r   [plc_pkg::DIV_STAGES];
  plc_pkg::plc_side_t        side_r  [plc_pkg::DIV_STAGES];
  logic                      rdy     [plc_pkg::DIV_STAGES+1];

  assign rdy[plc_pkg::DIV_STAGES] = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = valid_r[plc_pkg::DIV_STAGES-1];
  assign out_quot  = nq_r[plc_pkg::DIV_STAGES-1];
  assign out_side  = side_r[plc_pkg::DIV_STAGES-1];

  for (genvar k = 0; k < plc_pkg::DIV_STAGES; k++) begin : g_stage
    logic                 v_in;
    logic [31:0]          rem_in;
    logic [32:0]          nq_in;
    logic [31:0]          den_in;
    plc_pkg::plc_side_t   side_in;
    logic [31:0]          rem_nxt;
    logic [32:0]          nq_nxt;
    logic [32:0]          trial;

    if (k == 0) begin : g_src_port
      assign v_in    = in_valid;
      assign rem_in  = in_rem;
      assign nq_in   = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_src_stage
      assign v_in    = valid_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign rdy[k] = !valid_r[k] || rdy[k+1];

    // numerator bits leave the top of nq, quotient bits enter at the bottom
    always_comb begin
      rem_nxt = rem_in;
      nq_nxt  = nq_in;
      trial   = '0;
      for (int j = 0; j < plc_pkg::DIV_BPS; j++) begin
        trial  = {rem_nxt, nq_nxt[32]};
        nq_nxt = {nq_nxt[31:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial     = trial - {1'b0, den_in};
          nq_nxt[0] = 1'b1;
        end
        rem_nxt = trial[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[k]  <= rem_nxt;
        nq_r[k]   <= nq_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

endmodule

[hw/rtl/piecewise_linear_curve.sv]
// An evaluate item's result passes through 5 front stages, 11 divider stages and the
// output register; the first stage loads at the edge that accepts the item.
// Throughput: one item per cycle; the input stalls only while the result is held off.
// Write items update the table in the cycle they are accepted and give no result.
// Reset (synchronous, rst_n low) clears the table, node_count and all valid bits.
// Top level; depends on plc_pkg, plc_if and plc_div.
module piecewise_linear_curve (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [plc_pkg::CNT_W-1:0]     cfg_wdata,
  plc_in_if.sink                        in_item,
  plc_out_if.source                     out_item
);

  localparam int W = plc_pkg::DATA_W;

  logic [plc_pkg::CNT_W-1:0] count_r;
  logic signed [W-1:0]       params_r [plc_pkg::NODES];
  logic signed [W-1:0]       values_r [plc_pkg::NODES];

  // ---------------- table lookup, at accept ----------------
  logic [plc_pkg::CNT_W-1:0] n_eff;
  logic [plc_pkg::NODES-1:0] last_oh, hit, first_oh;
  logic                      found, seen;
  logic signed [W-1:0]       p_last, v_last, xm, x_c;
  logic signed [W-1:0]       pa_c, pb_c, va_c, vb_c;
  logic                      accept, rdy1;

  assign accept = in_item.valid && in_item.ready;

  always_comb begin
    n_eff = (count_r > plc_pkg::CNT_W'(plc_pkg::NODES)) ?
            plc_pkg::CNT_W'(plc_pkg::NODES) : count_r;
    p_last = '0;
    v_last = '0;
    for (int i = 0; i < plc_pkg::NODES; i++) begin
      last_oh[i] = (n_eff == plc_pkg::CNT_W'(i + 1));
      if (last_oh[i]) begin
        p_last = params_r[i];
        v_last = values_r[i];
      end
    end
    xm  = (in_item.query_param > p_last) ? p_last : in_item.query_param;
    x_c = xm[W-1] ? '0 : xm;
    // clamped query below p[i], split so it does not wait on x_c
    hit[0] = 1'b0;
    for (int i = 1; i < plc_pkg::NODES; i++) begin
      hit[i] = (plc_pkg::CNT_W'(i) < n_eff) &&
               ((in_item.query_param < params_r[i]) || (p_last < params_r[i])) &&
               (params_r[i] > 0);
    end
    seen = 1'b0;
    for (int i = 0; i < plc_pkg::NODES; i++) begin
      first_oh[i] = hit[i] && !seen;
      seen        = seen || hit[i];
    end
    found = seen;
    pa_c = '0;
    pb_c = '0;
    va_c = '0;
    vb_c = '0;
    for (int i = 0; i < plc_pkg::NODES; i++) begin
      if (first_oh[i]) begin
        pb_c = params_r[i];
        vb_c = values_r[i];
      end
      if (i < plc_pkg::NODES - 1) begin
        if (first_oh[i+1]) begin
          pa_c = params_r[i];
          va_c = values_r[i];
        end
      end
    end
    // past the last node: zero slope returns its value
    if (!found) begin
      pa_c = '0;
      pb_c = '0;
      va_c = v_last;
      vb_c = v_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < plc_pkg::NODES; i++) begin
        params_r[i] <= '0;
        values_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (accept && in_item.command == plc_pkg::CMD_WRITE &&
          int'(in_item.node_index) < plc_pkg::NODES) begin
        params_r[in_item.node_index[plc_pkg::IDX_W-1:0]] <= in_item.node_param;
        values_r[in_item.node_index[plc_pkg::IDX_W-1:0]] <= in_item.node_value;
      end
    end
  end

  // ---------------- pipeline control ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic rdy2, rdy3, rdy4, rdy5, div_in_ready, div_out_valid, rdy_out;

  assign rdy_out       = !out_valid_r || out_item.ready;
  assign rdy5          = !v5_r || div_in_ready;
  assign rdy4          = !v4_r || rdy5;
  assign rdy3          = !v3_r || rdy4;
  assign rdy2          = !v2_r || rdy3;
  assign rdy1          = !v1_r || rdy2;
  assign in_item.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_item.valid && in_item.command == plc_pkg::CMD_EVAL;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy4)    v4_r        <= v3_r;
      if (rdy5)    v5_r        <= v4_r;
      if (rdy_out) out_valid_r <= div_out_valid;
    end
  end

  // ---------------- stage 1: selected segment ----------------
  logic signed [W-1:0] x1_r, pa1_r, pb1_r, va1_r, vb1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r  <= x_c;
      pa1_r <= pa_c;
      pb1_r <= pb_c;
      va1_r <= va_c;
      vb1_r <= vb_c;
    end
  end

  // ---------------- stage 2: differences ----------------
  logic signed [W:0]   df2_r, st2_r, ds2_r;
  logic signed [W-1:0] va2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      df2_r <= {vb1_r[W-1], vb1_r} - {va1_r[W-1], va1_r};
      st2_r <= {x1_r[W-1], x1_r} - {pa1_r[W-1], pa1_r};
      ds2_r <= {pb1_r[W-1], pb1_r} - {pa1_r[W-1], pa1_r};
      va2_r <= va1_r;
    end
  end

  // ---------------- stage 3: magnitudes and sign ----------------
  // each difference magnitude stays below 2^32
  logic [W:0]          df_abs, st_abs, ds_abs;
  logic [W-1:0]        mdf3_r, mst3_r, mds3_r;
  logic                neg3_r;
  logic signed [W-1:0] va3_r;

  always_comb begin
    df_abs = df2_r[W] ? (W+1)'(-df2_r) : df2_r;
    st_abs = st2_r[W] ? (W+1)'(-st2_r) : st2_r;
    ds_abs = ds2_r[W] ? (W+1)'(-ds2_r) : ds2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mdf3_r <= df_abs[W-1:0];
      mst3_r <= st_abs[W-1:0];
      mds3_r <= ds_abs[W-1:0];
      neg3_r <= df2_r[W] ^ st2_r[W] ^ ds2_r[W];
      va3_r  <= va2_r;
    end
  end

  // ---------------- stage 4: product ----------------
  logic [2*W-1:0]      prod4_r;
  logic [W-1:0]        mds4_r;
  logic                neg4_r;
  logic signed [W-1:0] va4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      prod4_r <= {{W{1'b0}}, mdf3_r} * {{W{1'b0}}, mst3_r};
      mds4_r  <= mds3_r;
      neg4_r  <= neg3_r;
      va4_r   <= va3_r;
    end
  end

  // ---------------- stage 5: divider setup ----------------
  // high product bits at or above the divisor mean a quotient of 2^33 or more
  logic [W-1:0]        rem5_r, den5_r;
  logic [W:0]          num5_r;
  plc_pkg::plc_side_t  side5_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      rem5_r       <= {1'b0, prod4_r[2*W-1:W+1]};
      num5_r       <= prod4_r[W:0];
      den5_r       <= mds4_r;
      side5_r.neg  <= neg4_r;
      side5_r.zero <= (prod4_r == '0);
      side5_r.sat  <= (mds4_r == '0) || ({1'b0, prod4_r[2*W-1:W+1]} >= mds4_r);
      side5_r.va   <= va4_r;
    end
  end

  logic [W:0]          quot;
  plc_pkg::plc_side_t  side_q;

  plc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_ready  (div_in_ready),
    .in_rem    (rem5_r),
    .in_num    (num5_r),
    .in_den    (den5_r),
    .in_side   (side5_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_out),
    .out_quot  (quot),
    .out_side  (side_q)
  );

  // ---------------- output: signed add and saturation ----------------
  logic [W+1:0]        q_eff;
  logic [W+2:0]        addend, sum;
  logic signed [W-1:0] value_c, out_value_r;

  always_comb begin
    if (side_q.zero) begin
      q_eff = '0;
    end else if (side_q.sat) begin
      q_eff = (W+2)'(1) << (W + 1);
    end else begin
      q_eff = {1'b0, quot};
    end
    addend = {1'b0, q_eff} ^ {(W+3){side_q.neg}};
    sum    = {{3{side_q.va[W-1]}}, side_q.va} + addend + (W+3)'(side_q.neg);
    if (sum[W+2:W-1] == '0 || sum[W+2:W-1] == '1) begin
      value_c = sum[W-1:0];
    end else if (sum[W+2]) begin
      value_c = {1'b1, {(W-1){1'b0}}};
    end else begin
      value_c = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_value_r <= value_c;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.curve_value = out_value_r;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for piecewise_linear_curve: loads breakpoint tables, evaluates
// queries and compares each curve_value against an in-bench Q16.16 interpolator.
// Depends on plc_pkg, plc_if (plc_in_if, plc_out_if) and the block's RTL.
module tb;

  localparam int STALL_LIMIT   = 3000;  // cycles with no item moving on either channel
  localparam int SETTLE_CYCLES = 24;    // pipeline latency plus margin
  localparam logic signed [plc_pkg::DATA_W-1:0] ONE = 32'sh0001_0000;
  localparam longint CURVE_MAX = 2147483647;
  localparam longint CURVE_MIN = -CURVE_MAX - 1;
  localparam logic [127:0] QUOT_CAP = 128'd1 << 40;

  typedef struct packed {
    logic                              command;
    logic [plc_pkg::IDX_W-1:0]         node_index;
    logic signed [plc_pkg::DATA_W-1:0] node_param;
    logic signed [plc_pkg::DATA_W-1:0] node_value;
    logic signed [plc_pkg::DATA_W-1:0] query_param;
  } curve_req_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [plc_pkg::CNT_W-1:0] cfg_wdata;

  plc_in_if  in_ch();
  plc_out_if out_ch();

  piecewise_linear_curve i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  // Shadow of the block's table and count register
  logic signed [plc_pkg::DATA_W-1:0] node_param_tbl [plc_pkg::NODES];
  logic signed [plc_pkg::DATA_W-1:0] node_value_tbl [plc_pkg::NODES];
  logic [plc_pkg::CNT_W-1:0]         node_count_reg;

  logic signed [plc_pkg::DATA_W-1:0] expected_curve [$];

  int src_idle_pct;
  int snk_idle_pct;
  int sink_hold;
  int mismatches;
  int n_writes;
  int n_evals;
  int n_saturated;
  int n_settings;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic int used_nodes();
    return (node_count_reg > plc_pkg::NODES) ? plc_pkg::NODES : int'(node_count_reg);
  endfunction

  // Clamp, pick the segment, interpolate with exact product and truncating divide.
  function automatic logic signed [plc_pkg::DATA_W-1:0] curve_at(
      logic signed [plc_pkg::DATA_W-1:0] query);
    int           n;
    int           i;
    longint       x;
    longint       df;
    longint       ds;
    longint       st;
    longint       r;
    logic [127:0] prod;
    logic [127:0] quot;
    logic         neg;
    n = used_nodes();
    if (n == 0) return '0;
    x = longint'(query);
    if (x > longint'(node_param_tbl[n-1])) x = longint'(node_param_tbl[n-1]);
    if (x < 0) x = 0;
    r = longint'(node_value_tbl[n-1]);
    for (i = 1; i < n; i++) begin
      if (x < longint'(node_param_tbl[i])) begin
        df = longint'(node_value_tbl[i]) - longint'(node_value_tbl[i-1]);
        ds = longint'(node_param_tbl[i]) - longint'(node_param_tbl[i-1]);
        st = x - longint'(node_param_tbl[i-1]);
        neg = (df < 0) != (st < 0);
        prod = 128'(magnitude(df)) * 128'(magnitude(st));
        if (prod == 0) begin
          quot = '0;
        end else if (ds == 0) begin
          quot = QUOT_CAP;  // zero width: saturate with the numerator's sign
        end else begin
          quot = prod / 128'(magnitude(ds));
          if (quot > QUOT_CAP) quot = QUOT_CAP;
          if (ds < 0) neg = !neg;
        end
        r = longint'(node_value_tbl[i-1]) +
            (neg ? -longint'(quot[63:0]) : longint'(quot[63:0]));
        break;
      end
    end
    if (r > CURVE_MAX) r = CURVE_MAX;
    if (r < CURVE_MIN) r = CURVE_MIN;
    return r[plc_pkg::DATA_W-1:0];
  endfunction

  function automatic logic signed [plc_pkg::DATA_W-1:0] rand_query();
    int                                n;
    int                                pick;
    logic signed [plc_pkg::DATA_W-1:0] last;
    n = (used_nodes() == 0) ? 1 : used_nodes();
    last = node_param_tbl[n-1];
    pick = $urandom_range(99);
    if (pick < 30)
      return node_param_tbl[$urandom_range(n-1)] + $signed(32'($urandom_range(4))) - 2;
    if (pick < 50 && last > 0) return $urandom_range(0, last);
    if (pick < 65) return $urandom;
    if (pick < 75) return {1'b1, 31'($urandom)};
    if (pick < 85) begin
      case ($urandom_range(4))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return -1;
        3: return 1;
        default: return 0;
      endcase
    end
    return $urandom_range(0, 32'h0010_0000);
  endfunction

  // Offer one item, hold it until accepted, then update the shadow state.
  task automatic send_item(curve_req_t req);
    logic signed [plc_pkg::DATA_W-1:0] want;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= req.command;
    in_ch.node_index  <= req.node_index;
    in_ch.node_param  <= req.node_param;
    in_ch.node_value  <= req.node_value;
    in_ch.query_param <= req.query_param;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (req.command == plc_pkg::CMD_WRITE) begin
      node_param_tbl[req.node_index] = req.node_param;
      node_value_tbl[req.node_index] = req.node_value;
      n_writes++;
    end else begin
      want = curve_at(req.query_param);
      expected_curve.push_back(want);
      if (want == 32'sh7FFF_FFFF || want == 32'sh8000_0000) n_saturated++;
      n_evals++;
    end
  endtask

  task automatic write_node(logic [plc_pkg::IDX_W-1:0] idx,
                            logic signed [plc_pkg::DATA_W-1:0] p,
                            logic signed [plc_pkg::DATA_W-1:0] v);
    curve_req_t req;
    req.command     = plc_pkg::CMD_WRITE;
    req.node_index  = idx;
    req.node_param  = p;
    req.node_value  = v;
    req.query_param = $urandom;
    send_item(req);
  endtask

  task automatic eval_at(logic signed [plc_pkg::DATA_W-1:0] q);
    curve_req_t req;
    req.command     = plc_pkg::CMD_EVAL;
    req.node_index  = $urandom;
    req.node_param  = $urandom;
    req.node_value  = $urandom;
    req.query_param = q;
    send_item(req);
  endtask

  // Sender goes quiet until every pending evaluation has returned.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_curve.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_node_count(logic [plc_pkg::CNT_W-1:0] cnt);
    wait_drained();
    cfg_wdata <= cnt;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_reg = cnt;
    n_settings++;
  endtask

  task automatic load_random_table();
    int                                style;
    int                                i;
    logic signed [plc_pkg::DATA_W-1:0] p;
    logic signed [plc_pkg::DATA_W-1:0] v;
    logic [plc_pkg::DATA_W-1:0]        step_max;
    style = $urandom_range(99);
    step_max = ($urandom_range(3) == 0) ? 32'h0800_0000 : 32'h0004_0000;
    if (style < 10) p = -32'sh4000_0000;  // whole table below zero
    else if (style < 25) p = 32'sh1000_0000 + $urandom_range(0, 32'h0004_0000);
    else p = $signed(32'($urandom_range(0, 32'h0004_0000))) - ONE;
    for (i = 0; i < plc_pkg::NODES; i++) begin
      if ($urandom_range(99) < 70)
        v = $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
      else
        v = $urandom;
      if (style >= 90) p = $urandom;
      write_node(plc_pkg::IDX_W'(i), p, v);
      if (style >= 10 && style < 25) p = p - $urandom_range(1, step_max);
      else if (!(style >= 25 && style < 40 && $urandom_range(2) == 0))
        p = p + $urandom_range(1, step_max);
    end
  endtask

  task automatic test_empty_table();
    eval_at(32'sh7FFF_FFFF);
    eval_at(32'sh8000_0000);
    set_node_count(4'd15);  // above NODES, table still all zero
    eval_at(1);
  endtask

  task automatic test_segment_edges();
    logic signed [plc_pkg::DATA_W-1:0] pt [plc_pkg::NODES];
    logic signed [plc_pkg::DATA_W-1:0] vt [plc_pkg::NODES];
    int                                i;
    pt = '{ONE, 3*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE, 32'sh7FFF_FFFF};
    vt = '{32'sh8000_0000, 32'sh7FFF_FFFF, ONE, ONE, -2*ONE, 32'sh7FFF_FFFF,
           32'sh8000_0000, 3*ONE};
    for (i = 0; i < plc_pkg::NODES; i++) write_node(plc_pkg::IDX_W'(i), pt[i], vt[i]);
    set_node_count(4'd8);
    eval_at(0);                   // below node 0, extrapolated
    eval_at(32'sh8000_0000);      // clamped up to zero
    eval_at(2*ONE);
    eval_at(5*ONE);               // exactly on a node
    eval_at(8*ONE + ONE/2);
    eval_at(32'sh7FFF_FFFE);
    eval_at(32'sh7FFF_FFFF);      // last node, nothing exceeds it
  endtask

  task automatic test_degenerate_segments();
    write_node(plc_pkg::IDX_W'(0), 2*ONE, ONE);
    write_node(plc_pkg::IDX_W'(1), 2*ONE, 3*ONE);
    set_node_count(4'd2);
    eval_at(ONE);                 // zero width, quotient saturates
    eval_at(32'sh8000_0000);
    write_node(plc_pkg::IDX_W'(1), 2*ONE, ONE);
    eval_at(ONE);                 // zero width with a zero numerator
    write_node(plc_pkg::IDX_W'(1), ONE/2, -3*ONE);
    eval_at(ONE/4);               // falling abscissa, negative width
    write_node(plc_pkg::IDX_W'(1), -ONE, 32'sh7FFF_FFFF);
    eval_at(5*ONE);               // last abscissa below zero
  endtask

  task automatic test_stall_fill();
    set_node_count(4'd8);
    sink_hold = 400;
    repeat (60) eval_at(rand_query());
    wait_drained();
  endtask

  task automatic test_random_curves(int n_items);
    int sent;
    int pick;
    int cnt;
    int n_q;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6) cnt = 0;
      else if (pick < 12) cnt = 1;
      else if (pick < 22) cnt = $urandom_range(9, 15);
      else cnt = $urandom_range(2, 8);
      set_node_count(plc_pkg::CNT_W'(cnt));
      load_random_table();
      n_q = $urandom_range(10, 24);
      repeat (n_q) begin
        if ($urandom_range(99) < 8)
          write_node(plc_pkg::IDX_W'($urandom), $urandom, $urandom);
        else eval_at(rand_query());
      end
      sent += plc_pkg::NODES + n_q;
    end
  endtask

  // Result side: random stalls, or a counted hold-off when one is requested
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic signed [plc_pkg::DATA_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_curve.size() == 0) begin
        mismatches++;
        $display("%0t: curve_value expected none, got %h", $time, out_ch.curve_value);
      end else begin
        want = expected_curve.pop_front();
        if (out_ch.curve_value !== want) begin
          mismatches++;
          $display("%0t: curve_value expected %h, got %h", $time, want,
                   out_ch.curve_value);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.command     = plc_pkg::CMD_WRITE;
    in_ch.node_index  = '0;
    in_ch.node_param  = '0;
    in_ch.node_value  = '0;
    in_ch.query_param = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    node_count_reg    = '0;
    for (int i = 0; i < plc_pkg::NODES; i++) begin
      node_param_tbl[i] = '0;
      node_value_tbl[i] = '0;
    end
    sink_hold    = 0;
    mismatches   = 0;
    n_writes     = 0;
    n_evals      = 0;
    n_saturated  = 0;
    n_settings   = 0;
    src_idle_pct = 20;
    snk_idle_pct = 88;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_segment_edges();
    test_degenerate_segments();
    test_stall_fill();
    test_random_curves(150);
    src_idle_pct = 88;
    snk_idle_pct = 20;
    test_random_curves(150);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_curves(150);
    wait_drained();

    $display("summary: %0d table writes, %0d evaluations (%0d saturated), %0d count settings",
             n_writes, n_evals, n_saturated, n_settings);
    $display("summary: empty, clamped, extrapolated, degenerate and back-pressured cases run");
    if (mismatches == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
